// ===== rtl/lpt_pkg.sv =====
// Shared types, constants and the prefix mask helper function for the IPv6 prefix table.
package lpt_pkg;

  localparam int LPT_TABLE_DEPTH = 16;
  localparam logic [7:0] LPT_MAX_LEN = 8'd128;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } lpt_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } lpt_state_e;

  typedef struct packed {
    logic        opcode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_bits;
    logic [7:0]  iface_in;
  } lpt_req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] iface_out;
    logic       table_full;
  } lpt_rsp_t;

  typedef struct packed {
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  length;
    logic [7:0]  iface;
  } lpt_entry_t;

  localparam int LPT_ENTRY_W = $bits(lpt_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request word
    logic rd_en;   // read the table entry at rd_addr
    logic cmp_en;  // table data for cmp_idx is on the RAM output
    logic finish;  // commit the insert and present the result
  } lpt_cmd_t;

  // Network mask of a prefix of the given length (lengths above 128 saturate).
  function automatic logic [127:0] lpt_mask(input logic [7:0] len);
    logic [127:0] m;
    if (len >= LPT_MAX_LEN) begin
      m = {128{1'b1}};
    end else begin
      m = ~({128{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/lpt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lpt_ctrl.sv =====
// Controller state machine that sequences the table scan for each request.
module lpt_ctrl #(
  parameter int TABLE_DEPTH = lpt_pkg::LPT_TABLE_DEPTH
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   start,
  output logic                                                   busy,
  output lpt_pkg::lpt_cmd_t                                      cmd,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] cmp_idx
);
  import lpt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  lpt_state_e    state, state_next;
  logic [IW-1:0] cnt, cnt_next;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      rd_vld <= cmd.rd_en;
      rd_idx <= cnt;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cmp_en = rd_vld;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = ST_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LAST: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = cnt;
  assign cmp_idx = rd_idx;

endmodule

// ===== rtl/lpt_dp.sv =====
// Datapath: request registers, table storage, per-entry compare and result register.
module lpt_dp #(
  parameter int TABLE_DEPTH = lpt_pkg::LPT_TABLE_DEPTH
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  lpt_pkg::lpt_req_t                                      req,
  input  lpt_pkg::lpt_cmd_t                                      cmd,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] cmp_idx,
  output logic                                                   done,
  output lpt_pkg::lpt_rsp_t                                      rsp
);
  import lpt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Captured request. For inserts the key is already masked to its length.
  lpt_op_e      op;
  logic [127:0] key;
  logic [7:0]   len;
  logic [7:0]   ifc;

  logic [TABLE_DEPTH-1:0] valid;

  // Scan results.
  logic          acc_found;
  logic [7:0]    acc_len;
  logic [7:0]    acc_iface;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  logic [7:0]    len_sat;
  lpt_entry_t    ent, wr_ent;
  logic [LPT_ENTRY_W-1:0] rd_data;
  logic          ent_vld;
  logic          lk_match, ins_match;
  logic          wr_en;
  logic [IW-1:0] wr_slot;

  assign len_sat = (req.prefix_bits > LPT_MAX_LEN) ? LPT_MAX_LEN : req.prefix_bits;

  assign ent     = lpt_entry_t'(rd_data);
  assign ent_vld = valid[cmp_idx];

  assign lk_match  = ent_vld &&
                     (((key & lpt_mask(ent.length))) == {ent.prefix_high, ent.prefix_low});
  assign ins_match = ent_vld && (ent.length == len) &&
                     ({ent.prefix_high, ent.prefix_low} == key);

  assign wr_en   = cmd.finish && (op == OP_INSERT) && (hit_found || free_found);
  assign wr_slot = hit_found ? hit_idx : free_idx;

  always_comb begin
    wr_ent             = '0;
    wr_ent.prefix_high = key[127:64];
    wr_ent.prefix_low  = key[63:0];
    wr_ent.length      = len;
    wr_ent.iface       = ifc;
  end

  lpt_ram #(
    .WIDTH (LPT_ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (LPT_ENTRY_W'(wr_ent)),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= lpt_op_e'(req.opcode);
      len <= len_sat;
      ifc <= req.iface_in;
      if (req.opcode == OP_INSERT) begin
        key <= {req.addr_high, req.addr_low} & lpt_mask(len_sat);
      end else begin
        key <= {req.addr_high, req.addr_low};
      end
    end
  end

  // Scan accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_found  <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      acc_found  <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.cmp_en) begin
      if (op == OP_LOOKUP) begin
        if (lk_match && (!acc_found || (ent.length > acc_len))) begin
          acc_found <= 1'b1;
        end
      end else begin
        if (ins_match && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!ent_vld && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_len   <= '0;
      acc_iface <= '0;
    end else if (cmd.cmp_en) begin
      if ((op == OP_LOOKUP) && lk_match && (!acc_found || (ent.length > acc_len))) begin
        acc_len   <= ent.length;
        acc_iface <= ent.iface;
      end
      if ((op == OP_INSERT) && ins_match && !hit_found) begin
        hit_idx <= cmp_idx;
      end
      if ((op == OP_INSERT) && !ent_vld && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_slot] <= 1'b1;
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op == OP_INSERT) begin
        rsp.found      <= 1'b0;
        rsp.iface_out  <= '0;
        rsp.table_full <= !(hit_found || free_found);
      end else begin
        rsp.found      <= acc_found;
        rsp.iface_out  <= acc_iface;
        rsp.table_full <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ipv6_longest_prefix_table.sv =====
// Top level of the IPv6 on-link prefix table with longest-prefix-match lookup.
//
// The block holds up to TABLE_DEPTH IPv6 prefixes, each bound to an 8-bit
// interface number. A request word is accepted on a rising edge where start is
// high and busy is low. An insert (opcode 0) masks its address to prefix_bits
// (lengths above 128 count as 128), then rewrites the entry holding the same
// prefix and length, or else fills the lowest free slot; if there is neither,
// the insert is dropped and the result word carries table_full. A lookup
// (opcode 1) returns found and the interface of the longest matching valid
// prefix, with iface_out zero on a miss. Every request produces exactly one
// result word, shown on rsp for a single cycle while done is high; there is no
// way to hold it off, so the receiver must take it in that cycle. A request is
// taken only after the previous one is through: every request reads the entry
// memory through its single read port, one entry per cycle, then makes the
// last compare, commits any insert and registers the result, which is shown
// in the idle state in which the next request is taken. The done strobe
// appears in the first cycle in which busy is low again, so a new request
// may be issued in the same cycle the result is seen.
// Entry contents need no clearing after reset; only the per-entry valid bits
// are reset, so the block is ready right after reset deasserts.
module ipv6_longest_prefix_table #(
  parameter int TABLE_DEPTH = lpt_pkg::LPT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lpt_pkg::lpt_req_t req,
  output logic              done,
  output lpt_pkg::lpt_rsp_t rsp
);
  import lpt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  lpt_cmd_t      cmd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] cmp_idx;

  // The controller walks the table addresses; the datapath does the compares.
  lpt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .cmp_idx (cmp_idx)
  );

  lpt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .cmp_idx (cmp_idx),
    .done    (done),
    .rsp     (rsp)
  );

endmodule

// ===== rtl/lpt_chk.sv =====
// Port-level checker for the prefix table, bound to the top level.
module lpt_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input lpt_pkg::lpt_rsp_t rsp
);

  // A result word only appears once the block is ready again.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done asserted while busy");

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not make the block busy");

  // Busy can only rise because a request was accepted.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // A result never reports both a lookup hit and a dropped insert.
  a_rsp_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.found && rsp.table_full))
    else $error("result shows found and table_full together");

  // Without a hit the interface field is zero.
  a_miss_iface: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.iface_out == 8'd0))
    else $error("nonzero interface on a result without a hit");

endmodule

bind ipv6_longest_prefix_table lpt_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
